// ----- src/soft_wrap_row_builder_defines.svh -----
// ---------------------------------------------------------------------------
// soft_wrap_row_builder assertion macros
// shared check forms for the row builder, clocked on clk, held off in rst
// ---------------------------------------------------------------------------
`ifndef SOFT_WRAP_ROW_BUILDER_DEFINES_SVH
`define SOFT_WRAP_ROW_BUILDER_DEFINES_SVH

// same-cycle implication check
`define SWRB_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("soft_wrap_row_builder check failed");

// next-cycle implication check
`define SWRB_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("soft_wrap_row_builder check failed");

`endif

// ----- src/swrb_pkg.sv -----
// ---------------------------------------------------------------------------
// swrb_pkg
// types, widths and helpers shared by the soft wrap row builder modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swrb_pkg;

  // field widths
  localparam int ColW   = 10;
  localparam int LineW  = 16;
  localparam int SpanW  = 12;
  localparam int CountW = 13;
  localparam int CellW  = 20;
  localparam int EndW   = 17;

  // stream widths
  localparam int InDataW  = 32;
  localparam int RowW     = EndW + 2 * ColW + CellW + CountW + SpanW + LineW;
  localparam int OutDataW = ((RowW + 7) / 8) * 8;
  localparam int OutPadW  = OutDataW - RowW;

  // register reset and saturation limits
  localparam logic [ColW-1:0]   COLUMNS_RESET  = 10'd80;
  localparam logic [SpanW-1:0]  SPAN_POS_MAX   = {SpanW{1'b1}};
  localparam logic [CountW-1:0] SPAN_TOTAL_MAX = 13'd4096;
  localparam logic [CellW-1:0]  START_CELL_MAX = {CellW{1'b1}};

  // item queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // one row record, line_index in the lowest bits
  typedef struct packed {
    logic [EndW-1:0]   end_byte;
    logic [ColW-1:0]   visible_cells;
    logic [ColW-1:0]   content_cells;
    logic [CellW-1:0]  row_origin;
    logic [CountW-1:0] span_count;
    logic [SpanW-1:0]  head_span;
    logic [LineW-1:0]  line_index;
  } row_t;

  // rows caused by one item; a single row sits in row0
  typedef struct packed {
    logic two_rows;
    row_t row0;
    row_t row1;
  } item_rec_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // build a row record, clipping visible cells to the column count
  function automatic row_t make_row(
    input logic [LineW-1:0]  line,
    input logic [SpanW-1:0]  first,
    input logic [CountW-1:0] count,
    input logic [CellW-1:0]  start,
    input logic [ColW-1:0]   content,
    input logic [EndW-1:0]   end_b,
    input logic [ColW-1:0]   columns
  );
    row_t r;
    r.line_index    = line;
    r.head_span     = first;
    r.span_count    = count;
    r.row_origin    = start;
    r.content_cells = content;
    r.visible_cells = (content < columns) ? content : columns;
    r.end_byte      = end_b;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/swrb_front.sv -----
// ---------------------------------------------------------------------------
// swrb_front
// accepts spans, keeps the running row state and pushes finished rows
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrb_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [swrb_pkg::ColW-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [swrb_pkg::InDataW-1:0]      in_data,
  input  wire logic                              in_empty,
  input  wire logic                              in_last,
  input  wire swrb_pkg::q_stat_t                 q_stat,
  output logic                                   push,
  output swrb_pkg::item_rec_t                    rec
);

  // column count register
  logic [swrb_pkg::ColW-1:0] columns;

  // running line and row state
  logic [swrb_pkg::LineW-1:0]  line_counter;
  logic [swrb_pkg::SpanW-1:0]  span_position;
  logic [swrb_pkg::SpanW-1:0]  row_first_span;
  logic [swrb_pkg::CountW-1:0] row_span_total;
  logic [swrb_pkg::CellW-1:0]  row_start_cell;
  logic [swrb_pkg::ColW-1:0]   row_cell_sum;
  logic [swrb_pkg::EndW-1:0]   previous_span_end;

  logic [swrb_pkg::LineW-1:0]  line_counter_next;
  logic [swrb_pkg::SpanW-1:0]  span_position_next;
  logic [swrb_pkg::SpanW-1:0]  row_first_span_next;
  logic [swrb_pkg::CountW-1:0] row_span_total_next;
  logic [swrb_pkg::CellW-1:0]  row_start_cell_next;
  logic [swrb_pkg::ColW-1:0]   row_cell_sum_next;
  logic [swrb_pkg::EndW-1:0]   previous_span_end_next;

  logic                        accept;
  logic [7:0]                  width;
  logic [15:0]                 offset;
  logic [7:0]                  len;
  logic [swrb_pkg::ColW-1:0]   used;
  logic [swrb_pkg::ColW-1:0]   room;
  logic                        brk;
  logic [swrb_pkg::CellW:0]    start_sum;
  logic [swrb_pkg::CellW-1:0]  start_sat;
  logic [swrb_pkg::SpanW-1:0]  first_b;
  logic [swrb_pkg::CountW-1:0] total_b;
  logic [swrb_pkg::CellW-1:0]  start_b;
  logic [swrb_pkg::ColW-1:0]   sum_b;
  logic [swrb_pkg::CountW-1:0] total_n;
  logic [swrb_pkg::ColW-1:0]   sum_n;
  logic [swrb_pkg::EndW-1:0]   end_n;
  swrb_pkg::row_t              row_pend;
  swrb_pkg::row_t              row_done;
  swrb_pkg::row_t              row_empty0;
  swrb_pkg::row_t              row_empty1;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign width  = in_data[7:0];
  assign offset = in_data[23:8];
  assign len    = in_data[31:24];

  // fit test against the columns left on the row
  assign used = (row_cell_sum < columns) ? row_cell_sum : columns;
  assign room = columns - used;
  assign brk  = (width != 8'd0) && (row_cell_sum != '0)
                && ({2'b00, width} > room);

  // next row start, saturating
  assign start_sum = {1'b0, row_start_cell} + {11'd0, row_cell_sum};
  assign start_sat = start_sum[swrb_pkg::CellW] ? swrb_pkg::START_CELL_MAX
                                                : start_sum[swrb_pkg::CellW-1:0];

  // state after a possible break
  assign first_b = brk ? span_position : row_first_span;
  assign total_b = brk ? '0 : row_span_total;
  assign start_b = brk ? start_sat : row_start_cell;
  assign sum_b   = brk ? '0 : row_cell_sum;

  // state after placing the span
  assign total_n = (total_b == swrb_pkg::SPAN_TOTAL_MAX) ? total_b
                                                          : total_b + 13'd1;
  assign sum_n   = sum_b + {2'b00, width};
  assign end_n   = {1'b0, offset} + {9'd0, len};

  // candidate rows
  always_comb begin
    row_pend   = swrb_pkg::make_row(line_counter, row_first_span, row_span_total,
                                    row_start_cell, row_cell_sum,
                                    previous_span_end, columns);
    row_done   = swrb_pkg::make_row(line_counter, first_b, total_n, start_b,
                                    sum_n, end_n, columns);
    row_empty0 = swrb_pkg::make_row(line_counter, '0, '0, '0, '0, '0, columns);
    row_empty1 = swrb_pkg::make_row(line_counter + 16'd1, '0, '0, '0, '0, '0,
                                    columns);
  end

  // classify the item and work out the next state
  always_comb begin
    push                   = 1'b0;
    rec.two_rows           = 1'b0;
    rec.row0               = row_done;
    rec.row1               = row_done;
    line_counter_next      = line_counter;
    span_position_next     = '0;
    row_first_span_next    = '0;
    row_span_total_next    = '0;
    row_start_cell_next    = '0;
    row_cell_sum_next      = '0;
    previous_span_end_next = '0;
    if (in_empty) begin
      push = accept;
      if (row_span_total != '0) begin
        rec.two_rows      = 1'b1;
        rec.row0          = row_pend;
        rec.row1          = row_empty1;
        line_counter_next = line_counter + 16'd2;
      end else begin
        rec.row0          = row_empty0;
        line_counter_next = line_counter + 16'd1;
      end
    end else begin
      push         = accept && (brk || in_last);
      rec.two_rows = brk && in_last;
      rec.row0     = brk ? row_pend : row_done;
      if (in_last) begin
        line_counter_next = line_counter + 16'd1;
      end else begin
        span_position_next     = (span_position == swrb_pkg::SPAN_POS_MAX)
                                 ? span_position : span_position + 12'd1;
        row_first_span_next    = first_b;
        row_span_total_next    = total_n;
        row_start_cell_next    = start_b;
        row_cell_sum_next      = sum_n;
        previous_span_end_next = end_n;
      end
    end
  end

  // column register
  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= swrb_pkg::COLUMNS_RESET;
    end else if (cfg_we) begin
      columns <= cfg_wdata;
    end
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      line_counter      <= '0;
      span_position     <= '0;
      row_first_span    <= '0;
      row_span_total    <= '0;
      row_start_cell    <= '0;
      row_cell_sum      <= '0;
      previous_span_end <= '0;
    end else if (accept) begin
      line_counter      <= line_counter_next;
      span_position     <= span_position_next;
      row_first_span    <= row_first_span_next;
      row_span_total    <= row_span_total_next;
      row_start_cell    <= row_start_cell_next;
      row_cell_sum      <= row_cell_sum_next;
      previous_span_end <= previous_span_end_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/swrb_queue.sv -----
// ---------------------------------------------------------------------------
// swrb_queue
// short first-in first-out queue of item records between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrb_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire swrb_pkg::item_rec_t rec_in,
  input  wire logic                pop,
  output swrb_pkg::item_rec_t      rec_out,
  output swrb_pkg::q_stat_t        stat
);

  swrb_pkg::item_rec_t            slots [swrb_pkg::QDepth];
  logic [swrb_pkg::QPtrW-1:0]     wr_ptr;
  logic [swrb_pkg::QPtrW-1:0]     rd_ptr;
  logic [swrb_pkg::QCntW-1:0]     count;

  assign stat.full  = (count == swrb_pkg::QCntW'(swrb_pkg::QDepth));
  assign stat.empty = (count == '0);
  assign rec_out    = slots[rd_ptr];

  // record storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= rec_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + swrb_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + swrb_pkg::QPtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + swrb_pkg::QCntW'(1);
        2'b01:   count <= count - swrb_pkg::QCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/swrb_back.sv -----
// ---------------------------------------------------------------------------
// swrb_back
// walks the queued item records and sends their rows out one at a time
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrb_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire swrb_pkg::q_stat_t             q_stat,
  input  wire swrb_pkg::item_rec_t           rec,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [swrb_pkg::OutDataW-1:0]      out_data,
  output logic                               out_last
);

  swrb_pkg::row_t out_row;
  logic           sel;
  logic           load;
  logic           take;

  // output register free or draining this cycle
  assign load = !out_valid || out_ready;
  assign take = load && !q_stat.empty;
  assign pop  = take && (sel || !rec.two_rows);

  assign out_data = {{swrb_pkg::OutPadW{1'b0}}, out_row};

  // output control and second-row select
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
      if (take) begin
        sel <= sel ? 1'b0 : rec.two_rows;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_row  <= sel ? rec.row1 : rec.row0;
      out_last <= sel || !rec.two_rows;
    end
  end

endmodule

`default_nettype wire

// ----- src/soft_wrap_row_builder.sv -----
// ---------------------------------------------------------------------------
// soft_wrap_row_builder
// greedy soft-wrap of text spans into visual rows of a set column count
// ---------------------------------------------------------------------------
// The block takes one span or empty-line item per cycle while its 4-entry
// queue has room and emits row records; each item leaves 0, 1 or 2 rows.
// The back sends one row per cycle while m_axis_tready is high, so the
// sustained rate is one item per cycle when items average at most one row;
// a two-row item holds the output until both rows are sent. A first row
// passes the queue write, then the output register. Write the column count
// via cfg_we / cfg_wdata only while no item is in flight (not enforced).
`timescale 1ns / 1ps
`default_nettype none
`include "soft_wrap_row_builder_defines.svh"

module soft_wrap_row_builder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // column count register
  input  wire logic                          cfg_we,
  input  wire logic [swrb_pkg::ColW-1:0]     cfg_wdata,
  // span items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // cell_width[7:0], span_offset[23:8], span_bytes[31:24]
  input  wire logic [swrb_pkg::InDataW-1:0]  s_axis_tdata,
  // empty_line[0]
  input  wire logic                          s_axis_tuser,
  // last_in_line
  input  wire logic                          s_axis_tlast,
  // row items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // line_index[15:0], head_span[27:16], span_count[40:28], row_origin[60:41],
  // content_cells[70:61], visible_cells[80:71], end_byte[97:81], zeros above
  output logic [swrb_pkg::OutDataW-1:0]      m_axis_tdata,
  // last_of_item
  output logic                               m_axis_tlast
);

  swrb_pkg::q_stat_t   q_stat;
  swrb_pkg::item_rec_t push_rec;
  swrb_pkg::item_rec_t head_rec;
  logic                q_push;
  logic                q_pop;
  swrb_pkg::row_t      out_view;
  logic                row_is_empty;

  // span classification and row state
  swrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_empty  (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .q_stat    (q_stat),
    .push      (q_push),
    .rec       (push_rec)
  );

  // item record queue
  swrb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .rec_in  (push_rec),
    .pop     (q_pop),
    .rec_out (head_rec),
    .stat    (q_stat)
  );

  // row output sequencer
  swrb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .rec       (head_rec),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  // row fields as seen on the output bus
  assign out_view     = swrb_pkg::row_t'(m_axis_tdata[swrb_pkg::RowW-1:0]);
  assign row_is_empty = m_axis_tvalid && (out_view.span_count == '0);

  // checks
  `SWRB_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full)
  `SWRB_ASSERT_NOW(a_visible_clip, m_axis_tvalid, out_view.visible_cells <= out_view.content_cells)
  `SWRB_ASSERT_NOW(a_empty_row_last, row_is_empty, m_axis_tlast && (out_view.content_cells == '0))
  `SWRB_ASSERT_NEXT(a_second_row, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

`default_nettype wire
